[rtl/bba_pkg.sv]
`default_nettype none

package bba_pkg;

  localparam int unsigned MAX_BLOCKS    = 4096;
  localparam int unsigned MAP_WORD_BITS = 64;
  localparam int unsigned MAP_WORDS     = MAX_BLOCKS / MAP_WORD_BITS;

  localparam int unsigned BLK_W  = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W  = BLK_W + 1;
  localparam int unsigned BIT_W  = $clog2(MAP_WORD_BITS);
  localparam int unsigned ADDR_W = BLK_W - BIT_W;

  typedef logic [BLK_W-1:0]         blk_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [MAP_WORD_BITS-1:0] map_word_t;

  localparam logic       KIND_ALLOC = 1'b0;
  localparam logic       KIND_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_NOT_USED = 2'd2;
  localparam logic [1:0] STAT_RANGE    = 2'd3;

endpackage

`default_nettype wire

[rtl/bba_req_if.sv]
`default_nettype none

interface bba_req_if import bba_pkg::*; ();
  logic valid;
  logic ready;
  logic kind;
  blk_t block_number;

  modport source (output valid, output kind, output block_number, input ready);
  modport sink   (input valid, input kind, input block_number, output ready);
endinterface

`default_nettype wire

[rtl/bba_rsp_if.sv]
`default_nettype none

interface bba_rsp_if import bba_pkg::*; ();
  logic       valid;
  logic       ready;
  blk_t       granted_block;
  logic [1:0] status;

  modport source (output valid, output granted_block, output status, input ready);
  modport sink   (input valid, input granted_block, input status, output ready);
endinterface

`default_nettype wire

[rtl/bitmap_block_allocator_unit.sv]
// Free: an accepted item passes S_FCHK, where its bit is checked and cleared, and
// S_DONE to its result in the output register; out of range, it skips S_FCHK.
// Allocate: S_SCAN reads k bitmap words (k from 1 to 64), one per cycle from the one
// read port of the bitmap memory, then S_DONE; a zero count skips S_SCAN. One item is
// in work at a time; the next is taken once the result has moved to the output register.
// Reset is async: the bitmap reads all free at once (per-row valid bits); count = 4096.
`default_nettype none

module bitmap_block_allocator_unit import bba_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  bba_req_if.sink         req_i,
  bba_rsp_if.source       rsp_o,
  input  wire logic       cfg_we_i,
  input  wire cnt_t       cfg_wdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FCHK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [ADDR_W-1:0] chk_q, chk_d;
  blk_t              blk_q, blk_d;
  blk_t              res_grant_q, res_grant_d;
  logic [1:0]        res_status_q, res_status_d;
  logic              out_valid_q, out_valid_d;
  blk_t              out_grant_q;
  logic [1:0]        out_status_q;
  cnt_t              total_q;
  logic [MAP_WORDS-1:0] row_valid_q;

  map_word_t         mem_q [MAP_WORDS];
  map_word_t         rd_data_q;
  logic              rd_valid_q;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  map_word_t         wr_data;
  map_word_t         rdata;

  cnt_t              eff_count;
  cnt_t              rem;
  map_word_t         lim_mask;
  map_word_t         free_vec;
  logic [BIT_W-1:0]  free_idx;
  logic              req_fire;
  logic              out_load;

  assign eff_count = (total_q > cnt_t'(MAX_BLOCKS)) ? cnt_t'(MAX_BLOCKS) : total_q;
  assign req_fire  = req_i.valid && req_i.ready;
  assign rdata     = rd_valid_q ? rd_data_q : '0;

  // Blocks left from the start of the word under check; bits at or past the
  // count are masked off so they are never granted.
  assign rem      = eff_count - cnt_t'({chk_q, {BIT_W{1'b0}}});
  assign lim_mask = (rem >= cnt_t'(MAP_WORD_BITS)) ? '1 : ~('1 << rem[BIT_W-1:0]);
  assign free_vec = ~rdata & lim_mask;

  always_comb begin
    free_idx = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (free_vec[i]) free_idx = BIT_W'(i);
    end
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d      = state_q;
    chk_d        = chk_q;
    blk_d        = blk_q;
    res_grant_d  = res_grant_q;
    res_status_d = res_status_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    mem_we       = 1'b0;
    wr_addr      = chk_q;
    wr_data      = rdata;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          res_grant_d = '0;
          if (req_i.kind == KIND_ALLOC) begin
            if (eff_count == '0) begin
              res_status_d = STAT_FULL;
              state_d      = S_DONE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
              chk_d   = '0;
              state_d = S_SCAN;
            end
          end else begin
            if ({1'b0, req_i.block_number} >= eff_count) begin
              res_status_d = STAT_RANGE;
              state_d      = S_DONE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = req_i.block_number[BLK_W-1:BIT_W];
              blk_d   = req_i.block_number;
              state_d = S_FCHK;
            end
          end
        end
      end
      S_SCAN: begin
        // The next word is read ahead; nothing is written until the scan ends,
        // so the read-ahead never meets a pending write to the same word.
        rd_en   = 1'b1;
        rd_addr = chk_q + ADDR_W'(1);
        chk_d   = chk_q + ADDR_W'(1);
        if (|free_vec) begin
          mem_we       = 1'b1;
          wr_addr      = chk_q;
          wr_data      = rdata | (map_word_t'(1) << free_idx);
          res_grant_d  = {chk_q, free_idx};
          res_status_d = STAT_OK;
          state_d      = S_DONE;
        end else if (rem <= cnt_t'(MAP_WORD_BITS)) begin
          res_status_d = STAT_FULL;
          state_d      = S_DONE;
        end
      end
      S_FCHK: begin
        wr_addr = blk_q[BLK_W-1:BIT_W];
        if (rdata[blk_q[BIT_W-1:0]]) begin
          mem_we       = 1'b1;
          wr_data      = rdata & ~(map_word_t'(1) << blk_q[BIT_W-1:0]);
          res_status_d = STAT_OK;
        end else begin
          res_status_d = STAT_NOT_USED;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (rsp_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      total_q     <= cnt_t'(MAX_BLOCKS);
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) total_q <= cfg_wdata_i;
      if (mem_we) row_valid_q[wr_addr] <= 1'b1;
      if (rd_en) rd_valid_q <= row_valid_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q        <= chk_d;
    blk_q        <= blk_d;
    res_grant_q  <= res_grant_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_grant_q  <= res_grant_q;
      out_status_q <= res_status_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.granted_block = out_grant_q;
  assign rsp_o.status        = out_status_q;

`ifndef ASSERT_OFF
  a_grant_zero_unless_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != STAT_OK) |-> rsp_o.granted_block == '0)
    else $error("granted block is nonzero on a failed item");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cnt_t'({chk_q, {BIT_W{1'b0}}}) < eff_count))
    else $error("scan went past the block count");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && rd_en |-> (wr_addr != rd_addr))
    else $error("bitmap read and write hit the same word in one cycle");

  a_fchk_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FCHK) |=> (state_q == S_DONE))
    else $error("free check did not finish in one cycle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rsp_o.ready |=> $stable(out_grant_q) && $stable(out_status_q))
    else $error("waiting result was overwritten");
`endif

endmodule

`default_nettype wire

[bench/bitmap_block_allocator_unit_tb.sv]
`timescale 1ns / 100ps

module bitmap_block_allocator_unit_tb;
  import bba_pkg::*;

  typedef struct packed {
    logic kind;
    blk_t block_number;
  } block_req_t;

  typedef struct packed {
    blk_t       granted_block;
    logic [1:0] status;
  } block_rsp_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  cnt_t cfg_wdata_i;

  bba_req_if req_if ();
  bba_rsp_if rsp_if ();

  bitmap_block_allocator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Mirror of the allocator: one bit per block plus the programmed count.
  logic [MAX_BLOCKS-1:0] blocks_taken;
  cnt_t                  managed_count;

  block_req_t pending_reqs[$];
  block_rsp_t expected_rsps[$];

  int fail_count;
  int allocs_queued;
  int count_settings;
  int n_granted, n_full, n_not_used, n_range;
  bit quiet_run;
  int gap_left;
  int stall_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #15_000_000;
    $display("Watchdog expired with %0d requests pending and %0d results outstanding",
             pending_reqs.size(), expected_rsps.size());
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int unsigned usable_blocks();
    return (managed_count > MAX_BLOCKS) ? MAX_BLOCKS : managed_count;
  endfunction

  function automatic block_rsp_t predict_allocation(block_req_t req);
    block_rsp_t  rsp;
    int unsigned limit;
    rsp.granted_block = '0;
    limit = usable_blocks();
    if (req.kind == KIND_ALLOC) begin
      rsp.status = STAT_FULL;
      for (int unsigned b = 0; b < limit; b++) begin
        if (!blocks_taken[b]) begin
          blocks_taken[b]   = 1'b1;
          rsp.granted_block = blk_t'(b);
          rsp.status        = STAT_OK;
          break;
        end
      end
    end else if (req.block_number >= limit) begin
      rsp.status = STAT_RANGE;
    end else if (!blocks_taken[req.block_number]) begin
      rsp.status = STAT_NOT_USED;
    end else begin
      blocks_taken[req.block_number] = 1'b0;
      rsp.status = STAT_OK;
    end
    return rsp;
  endfunction

  // Request driver: the next item is presented once the current one is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid        <= 1'b0;
      req_if.kind         <= KIND_ALLOC;
      req_if.block_number <= '0;
      gap_left = 0;
    end else if (!req_if.valid || req_if.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (!quiet_run && pending_reqs.size() != 0 && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 13);
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        block_req_t nxt;
        nxt = pending_reqs.pop_front();
        req_if.valid        <= 1'b1;
        req_if.kind         <= nxt.kind;
        req_if.block_number <= nxt.block_number;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Result sink with random back-pressure bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 13);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      block_req_t taken;
      taken.kind         = req_if.kind;
      taken.block_number = req_if.block_number;
      expected_rsps.push_back(predict_allocation(taken));
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      block_rsp_t want;
      if (expected_rsps.size() == 0) begin
        $error("result with no request outstanding: granted_block %0d, status %0d",
               rsp_if.granted_block, rsp_if.status);
        fail_count++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_if.granted_block !== want.granted_block) begin
          $error("granted_block mismatch: expected %0d, actual %0d",
                 want.granted_block, rsp_if.granted_block);
          fail_count++;
        end
        if (rsp_if.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, rsp_if.status);
          fail_count++;
        end
        case (want.status)
          STAT_OK:       if (want.granted_block != '0 || rsp_if.granted_block != '0) n_granted++;
          STAT_FULL:     n_full++;
          STAT_NOT_USED: n_not_used++;
          default:       n_range++;
        endcase
      end
    end
  end

  task automatic push_req(input logic kind, input blk_t block_number);
    block_req_t item;
    item.kind         = kind;
    item.block_number = block_number;
    pending_reqs.push_back(item);
    if (kind == KIND_ALLOC) allocs_queued++;
  endtask

  // Checked at the falling edge so that the driver's and monitor's updates
  // from the rising edge have all settled.
  task automatic wait_until_drained();
    while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0)
      @(negedge clk_i);
  endtask

  // The count register may only change while nothing is in flight.
  task automatic set_block_count(input cnt_t value);
    wait_until_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    managed_count = value;
    count_settings++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_random_phase(input int n_items, input int alloc_pct);
    int unsigned reach;
    int unsigned hot;
    for (int i = 0; i < n_items; i++) begin
      reach = usable_blocks();
      if ($urandom_range(1, 100) <= alloc_pct) begin
        push_req(KIND_ALLOC, blk_t'($urandom));
      end else begin
        // Frees mostly target the low region where grants accumulate; the
        // upper end may land exactly on the count to hit the range check.
        hot = (allocs_queued < reach) ? allocs_queued : reach;
        if (hot > MAX_BLOCKS - 1) hot = MAX_BLOCKS - 1;
        if ($urandom_range(0, 9) < 8) push_req(KIND_FREE, blk_t'($urandom_range(0, hot)));
        else push_req(KIND_FREE, blk_t'($urandom));
      end
    end
  endtask

  function automatic cnt_t pick_block_count();
    case ($urandom_range(0, 6))
      0:       return cnt_t'($urandom_range(1, 8));
      1:       return cnt_t'($urandom_range(9, 200));
      2:       return cnt_t'(63 + $urandom_range(0, 2) + 64 * $urandom_range(0, 1));
      3:       return cnt_t'(MAX_BLOCKS);
      4:       return cnt_t'($urandom_range(MAX_BLOCKS + 1, 8191));
      5:       return cnt_t'($urandom_range(201, MAX_BLOCKS - 1));
      default: return cnt_t'($urandom_range(0, 3));
    endcase
  endfunction

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    req_if.valid        = 1'b0;
    req_if.kind         = KIND_ALLOC;
    req_if.block_number = '0;
    rsp_if.ready        = 1'b0;
    blocks_taken        = '0;
    managed_count       = cnt_t'(MAX_BLOCKS);
    quiet_run           = 1'b0;
    fail_count          = 0;
    allocs_queued       = 0;
    count_settings      = 0;
    n_granted = 0;
    n_full = 0;
    n_not_used = 0;
    n_range = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: grants from the bottom, double free, top block number.
    push_req(KIND_ALLOC, '0);
    push_req(KIND_ALLOC, '1);
    push_req(KIND_FREE, blk_t'(0));
    push_req(KIND_FREE, blk_t'(0));
    push_req(KIND_ALLOC, '0);
    push_req(KIND_FREE, blk_t'(MAX_BLOCKS - 1));
    push_req(KIND_FREE, blk_t'(1));

    // A zero count manages nothing.
    set_block_count('0);
    push_req(KIND_ALLOC, '0);
    push_req(KIND_FREE, blk_t'(0));

    // Count lowered below blocks already in use: block 0 stays taken.
    set_block_count(cnt_t'(1));
    push_req(KIND_ALLOC, '0);
    push_req(KIND_FREE, blk_t'(0));
    push_req(KIND_ALLOC, '0);
    push_req(KIND_ALLOC, '0);
    push_req(KIND_FREE, blk_t'(1));

    // Counts past the store behave as the full store.
    set_block_count('1);
    push_req(KIND_FREE, blk_t'(MAX_BLOCKS - 1));
    push_req(KIND_ALLOC, '0);
    push_req(KIND_FREE, blk_t'(2048));
    set_block_count(cnt_t'(MAX_BLOCKS + 1));
    push_req(KIND_FREE, blk_t'(1));
    push_req(KIND_ALLOC, '0);
    push_req(KIND_FREE, blk_t'(MAX_BLOCKS - 1));
    set_block_count(cnt_t'(MAX_BLOCKS));
    push_req(KIND_FREE, blk_t'(MAX_BLOCKS - 1));

    // Random phases, each under a freshly picked count; every phase drains first.
    for (int p = 0; p < 10; p++) begin
      set_block_count(pick_block_count());
      quiet_run = ($urandom_range(0, 4) == 0);
      queue_random_phase($urandom_range(80, 120), $urandom_range(40, 70));
    end

    // Fill the map deep so allocations scan many words.
    set_block_count(cnt_t'(MAX_BLOCKS));
    quiet_run = 1'b0;
    queue_random_phase(900, 92);

    // Closing stretch without idling on either side.
    set_block_count(pick_block_count());
    quiet_run = 1'b1;
    queue_random_phase(100, 55);

    wait_until_drained();
    repeat (80) @(posedge clk_i);
    if (expected_rsps.size() != 0) begin
      $error("%0d expected results never arrived", expected_rsps.size());
      fail_count++;
    end

    $display("Covered %0d block-count settings and %0d allocate requests.",
             count_settings, allocs_queued);
    $display("Results: %0d nonzero grants, %0d full, %0d frees of free blocks, %0d out of range.",
             n_granted, n_full, n_not_used, n_range);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
